// ----- sv/prns_pkg.sv -----
// Shared constants, widths and types of the periodic radius neighbour search unit.
`default_nettype none

package prns_pkg;

    localparam int MAX_PARTICLES  = 4096;
    localparam int MAX_NEIGHBOURS = 64;
    localparam int COORD_BITS     = 20;

    // Field widths fixed by the interface.
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 20;
    localparam int CFGI_W  = 3;
    localparam int PCNT_W  = 13;

    // Derived widths.
    localparam int AW      = $clog2(MAX_PARTICLES);
    localparam int CW      = $clog2(MAX_PARTICLES + 1);
    localparam int POS_W   = 3 * COORD_BITS;
    localparam int DW      = COORD_BITS + 3;      // signed difference
    localparam int MW      = COORD_BITS + 1;      // corrected magnitude
    localparam int SQ_W    = 2 * MW;
    localparam int SUM_W   = SQ_W + 2;
    localparam int R2_W    = 2 * COORD_BITS;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_BOX_X  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_BOX_Y  = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_BOX_Z  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_PMASK  = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_PCOUNT = 3'd4;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Candidate entering the distance pipeline.
    typedef struct packed {
        logic          v;
        logic [AW-1:0] idx;
    } t_probe;

    // Verdict leaving the distance pipeline.
    typedef struct packed {
        logic          v;
        logic          near;
        logic [AW-1:0] idx;
        logic          busy;
    } t_verdict;

endpackage

`default_nettype wire

// ----- sv/periodic_radius_neighbour_search_unit.sv -----
// Top level of the periodic fixed-radius neighbour search unit.
//
// Command channel: a request is taken when i_start is high and o_busy is low.
//   Load (i_cmd 0) writes one position into the store in that cycle; o_busy
//   stays low, so loads can follow back to back.
//   Query (i_cmd 1) reads the named particle, then streams particles
//   0 .. particle_count-1 from the store, one per cycle, through a four-stage
//   distance pipeline.
// Results: one per hit, on o_* for one cycle with o_result_strobe high. The
//   receiver cannot stall. Each hit is held back until the next hit or the end
//   of the scan so that the final one carries o_last_hit and o_list_full.
//   A query without hits gives one result with o_hit_valid low.
// Busy: a query holds busy through query read, scan, pipeline drain and final
//   state, skipping the scan when the count is zero and ending early when the
//   neighbour limit is reached; the final result leaves in the first idle cycle.
// Config: i_cfg_valid / o_cfg_ready write channel, always ready; write only
//   when idle.
// Reset: synchronous, active low; registers take their reset values, the
//   position store is not cleared and must be loaded before a query.
`default_nettype none

module periodic_radius_neighbour_search_unit
    import prns_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_cmd,
    input  wire logic [IDX_W-1:0]      i_particle_index,
    input  wire logic [COORD_BITS-1:0] i_pos_x,
    input  wire logic [COORD_BITS-1:0] i_pos_y,
    input  wire logic [COORD_BITS-1:0] i_pos_z,
    input  wire logic [COORD_BITS-1:0] i_search_radius,
    // config channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFGI_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // results
    output logic                       o_result_strobe,
    output logic [IDX_W-1:0]           o_neighbour_index,
    output logic                       o_hit_valid,
    output logic                       o_last_hit,
    output logic [CNT_W-1:0]           o_hit_count,
    output logic                       o_list_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QLOAD = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    localparam logic [CNT_W-1:0] HIT_LIMIT = CNT_W'(MAX_NEIGHBOURS);

    // config registers
    logic [COORD_BITS-1:0] r_box_x, r_box_y, r_box_z;
    logic [2:0]            r_pmask;
    logic [PCNT_W-1:0]     r_pcount;

    // control
    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_addr;
    logic [CW-1:0]         r_n;
    logic [POS_W-1:0]      r_query;
    logic [R2_W-1:0]       r_r2;
    logic                  r_rd_v;
    logic [AW-1:0]         r_rd_idx;
    logic [CNT_W-1:0]      r_hits;
    logic                  r_pend_v;
    logic [AW-1:0]         r_pend_idx;

    // result register
    logic                  r_out_v;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_hv;
    logic                  r_out_last;
    logic [CNT_W-1:0]      r_out_cnt;
    logic                  r_out_full;

    logic                  w_accept;
    logic                  w_in_range;
    logic                  w_we;
    logic [AW-1:0]         w_raddr;
    logic [POS_W-1:0]      w_rdata;
    t_probe                w_probe;
    t_verdict              w_verdict;
    logic                  w_hit;
    logic [CNT_W-1:0]      w_hits_inc;
    logic                  w_flush;
    logic                  w_issue;

    assign w_accept   = i_start && !o_busy;
    assign w_in_range = 32'(i_particle_index) < MAX_PARTICLES;
    assign w_we       = w_accept && (i_cmd == CMD_LOAD) && w_in_range;
    assign w_raddr    = (r_state == S_IDLE) ? AW'(i_particle_index) : r_addr[AW-1:0];
    assign w_flush    = (r_state == S_FINAL);

    prns_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_particle_index)),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_probe.v   = r_rd_v;
    assign w_probe.idx = r_rd_idx;

    prns_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (w_flush),
        .i_probe   (w_probe),
        .i_pos     (w_rdata),
        .i_query   (r_query),
        .i_box     ({r_box_z, r_box_y, r_box_x}),
        .i_wrap    (r_pmask),
        .i_r2      (r_r2),
        .o_verdict (w_verdict)
    );

    // A hit only counts while the scan is live; after the limit it is ignored.
    assign w_hit      = w_verdict.v && w_verdict.near
                     && ((r_state == S_SCAN) || (r_state == S_DRAIN));
    assign w_hits_inc = r_hits + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == CMD_QUERY)) begin
                    n_state = w_in_range ? S_QLOAD : S_FINAL;
                end
            end
            S_QLOAD: n_state = (r_n == '0) ? S_DRAIN : S_SCAN;
            S_SCAN: begin
                if (r_addr == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !w_verdict.busy) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // limit reached: stop at once
        if (w_hit && (w_hits_inc == HIT_LIMIT)) begin
            n_state = S_FINAL;
        end
    end

    // one store read issued per scan cycle
    assign w_issue = (r_state == S_SCAN) && (r_addr != r_n) && (n_state == S_SCAN);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x  <= '1;
            r_box_y  <= '1;
            r_box_z  <= '1;
            r_pmask  <= '0;
            r_pcount <= PCNT_W'(4096);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BOX_X:  r_box_x  <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_Y:  r_box_y  <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_Z:  r_box_z  <= i_cfg_data[COORD_BITS-1:0];
                CFG_PMASK:  r_pmask  <= i_cfg_data[2:0];
                CFG_PCOUNT: r_pcount <= i_cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_v   <= 1'b0;
            r_hits   <= '0;
            r_pend_v <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_issue;
            if ((r_state == S_IDLE) && w_accept && (i_cmd == CMD_QUERY)) begin
                r_hits   <= '0;
                r_pend_v <= 1'b0;
                r_addr   <= '0;
            end
            if (w_issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_hit) begin
                r_hits   <= w_hits_inc;
                r_pend_v <= 1'b1;
            end
        end
    end

    // query payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_accept) begin
            r_r2 <= R2_W'(i_search_radius) * R2_W'(i_search_radius);
            r_n  <= (32'(r_pcount) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(r_pcount);
        end
        if (r_state == S_QLOAD) begin
            r_query <= w_rdata;
        end
        r_rd_idx <= r_addr[AW-1:0];
        if (w_hit) begin
            r_pend_idx <= w_verdict.idx;
        end
    end

    // result register: previous hit goes out when a new one arrives,
    // the held one goes out as final
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= (w_hit && r_pend_v) || (r_state == S_FINAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL) begin
            r_out_idx  <= r_pend_v ? IDX_W'(r_pend_idx) : '0;
            r_out_hv   <= r_pend_v;
            r_out_last <= 1'b1;
            r_out_cnt  <= r_pend_v ? r_hits : '0;
            r_out_full <= r_pend_v && (r_hits == HIT_LIMIT);
        end else begin
            r_out_idx  <= IDX_W'(r_pend_idx);
            r_out_hv   <= 1'b1;
            r_out_last <= 1'b0;
            r_out_cnt  <= r_hits;
            r_out_full <= 1'b0;
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_result_strobe   = r_out_v;
    assign o_neighbour_index = r_out_idx;
    assign o_hit_valid       = r_out_hv;
    assign o_last_hit        = r_out_last;
    assign o_hit_count       = r_out_cnt;
    assign o_list_full       = r_out_full;

    // an empty result is always the final one
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_hit_valid) |-> o_last_hit)
        else $error("empty result not marked last");

    // the count never passes the list limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_hit_count <= HIT_LIMIT))
        else $error("hit count beyond limit");

    // full flag only on the last result, at exactly the limit
    a_full_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_list_full) |-> (o_last_hit && (o_hit_count == HIT_LIMIT)))
        else $error("list_full without limit");

    // a final result comes in the cycle after the final state, with the block idle again
    a_final_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |=> (!o_busy && o_result_strobe && o_last_hit))
        else $error("final result missing");

    // an accepted query keeps the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_QUERY)) |=> o_busy)
        else $error("query did not raise busy");

endmodule

`default_nettype wire

// ----- sv/prns_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/prns_dist.sv -----
// Four-stage squared-distance pipeline with minimum-image correction and radius compare.
`default_nettype none

module prns_dist
    import prns_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_flush,
    input  wire t_probe                i_probe,
    input  wire logic [POS_W-1:0]      i_pos,
    input  wire logic [POS_W-1:0]      i_query,
    input  wire logic [POS_W-1:0]      i_box,
    input  wire logic [2:0]            i_wrap,
    input  wire logic [R2_W-1:0]       i_r2,
    output t_verdict                   o_verdict
);

    logic                       r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]              r_i1, r_i2, r_i3, r_i4;
    logic signed [DW-1:0]       r_d   [3];
    logic [MW-1:0]              r_m   [3];
    logic [SQ_W-1:0]            r_sq  [3];
    logic                       r_near;

    logic signed [DW-1:0]       w_d   [3];
    logic [MW-1:0]              w_m   [3];
    logic [SUM_W-1:0]           w_sum;

    // Stage 1 difference, stage 2 one-shot wrap and magnitude.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [DW-1:0] d1;
            logic signed [DW-1:0] d2;
            logic signed [DW-1:0] bx;
            w_d[a] = $signed({{(DW-COORD_BITS){1'b0}}, i_query[a*COORD_BITS +: COORD_BITS]})
                   - $signed({{(DW-COORD_BITS){1'b0}}, i_pos[a*COORD_BITS +: COORD_BITS]});
            bx = $signed({{(DW-COORD_BITS){1'b0}}, i_box[a*COORD_BITS +: COORD_BITS]});
            d1 = (i_wrap[a] && ((r_d[a] <<< 1) > bx)) ? r_d[a] - bx : r_d[a];
            d2 = (i_wrap[a] && ((d1 <<< 1) < -bx)) ? d1 + bx : d1;
            w_m[a] = d2[DW-1] ? MW'(-d2) : MW'(d2);
        end
        w_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_probe.v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= i_probe.idx;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        for (int a = 0; a < 3; a++) begin
            r_d[a]  <= w_d[a];
            r_m[a]  <= w_m[a];
            r_sq[a] <= SQ_W'(r_m[a]) * SQ_W'(r_m[a]);
        end
        r_near <= w_sum < SUM_W'(i_r2);
    end

    assign o_verdict.v    = r_v4;
    assign o_verdict.near = r_near;
    assign o_verdict.idx  = r_i4;
    assign o_verdict.busy = r_v1 | r_v2 | r_v3 | r_v4;

endmodule

`default_nettype wire
